// ===== rtl/core/matrix_vector_multiply_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the matrix-vector multiplier
// Both macros sample on the rising edge of clk and are disabled during reset.
// ---------------------------------------------------------------------------
`ifndef MATRIX_VECTOR_MULTIPLY_DEFINES_SVH
`define MATRIX_VECTOR_MULTIPLY_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MVM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MVM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mvm_pkg.sv =====
// ---------------------------------------------------------------------------
// mvm_pkg
// Shared types and constants of the matrix-vector multiplier.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mvm_pkg;

    localparam int CNT_W     = 5;   // width of the row and column counts
    localparam int ROW_W     = 4;
    localparam int COL_W     = 4;
    localparam int DATA_W    = 16;  // Q7.8 operands and results
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = PROD_W + 6;
    localparam int FRAC_W    = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 2'd1;

    localparam logic KIND_WEIGHT = 1'b0;
    localparam logic KIND_VECTOR = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } mvm_state_t;

    // Travels alongside each weight/vector read through the MAC pipeline.
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             lastcol;
        logic             lastrow;
        logic [ROW_W-1:0] row;
    } mvm_tag_t;

    typedef struct packed {
        logic busy;
        logic stall;
    } mvm_status_t;

endpackage

// ===== rtl/core/mvm_ram.sv =====
// ---------------------------------------------------------------------------
// mvm_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/mvm_mac.sv =====
// ---------------------------------------------------------------------------
// mvm_mac
// Shared multiply-accumulate pipeline with floor shift, saturation and the
// result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mvm_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mvm_pkg::mvm_tag_t                   issue_tag,
    input  logic [mvm_pkg::DATA_W-1:0]          w_data,
    input  logic [mvm_pkg::DATA_W-1:0]          v_data,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [mvm_pkg::ROW_W-1:0]           out_row,
    output logic signed [mvm_pkg::DATA_W-1:0]   dot_value,
    output logic                                saturated,
    output logic                                last,
    output mvm_pkg::mvm_status_t                status
);

    localparam int QW = mvm_pkg::ACC_W - mvm_pkg::FRAC_W;

    mvm_pkg::mvm_tag_t                s1_tag_reg;
    mvm_pkg::mvm_tag_t                p_tag_reg;
    logic signed [mvm_pkg::PROD_W-1:0] prod_reg;
    logic signed [mvm_pkg::ACC_W-1:0]  acc_reg;
    logic signed [mvm_pkg::ACC_W-1:0]  acc_next;
    logic                              fin_valid_reg;
    logic                              fin_lastrow_reg;
    logic [mvm_pkg::ROW_W-1:0]         fin_row_reg;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [mvm_pkg::ROW_W-1:0]         out_row_reg;
    logic signed [mvm_pkg::DATA_W-1:0] dot_reg;
    logic                              sat_reg;
    logic                              last_reg;
    logic                              stall;
    logic signed [QW-1:0]              q;
    logic                              q_ovf;
    logic signed [mvm_pkg::DATA_W-1:0] q_sat;

    // Everything freezes while a finished result waits to be taken.
    assign stall = out_valid_reg && !out_ready;

    assign acc_next = p_tag_reg.first
        ? {{(mvm_pkg::ACC_W - mvm_pkg::PROD_W){prod_reg[mvm_pkg::PROD_W-1]}}, prod_reg}
        : acc_reg + {{(mvm_pkg::ACC_W - mvm_pkg::PROD_W){prod_reg[mvm_pkg::PROD_W-1]}},
                     prod_reg};

    // An arithmetic shift of the accumulator floors toward minus infinity.
    assign q     = acc_reg[mvm_pkg::ACC_W-1:mvm_pkg::FRAC_W];
    assign q_ovf = !((&q[QW-1:mvm_pkg::DATA_W-1]) || !(|q[QW-1:mvm_pkg::DATA_W-1]));
    assign q_sat = q_ovf ? (q[QW-1] ? 16'sh8000 : 16'sh7FFF) : q[mvm_pkg::DATA_W-1:0];

    assign out_valid_next = stall ? 1'b1 : fin_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg    <= '0;
            p_tag_reg     <= '0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (!stall)
            begin
                s1_tag_reg    <= issue_tag;
                p_tag_reg     <= s1_tag_reg;
                fin_valid_reg <= p_tag_reg.valid && p_tag_reg.lastcol;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            prod_reg <= $signed(w_data) * $signed(v_data);
            if (p_tag_reg.valid)
            begin
                acc_reg         <= acc_next;
                fin_row_reg     <= p_tag_reg.row;
                fin_lastrow_reg <= p_tag_reg.lastrow;
            end
            if (fin_valid_reg)
            begin
                out_row_reg <= fin_row_reg;
                dot_reg     <= q_sat;
                sat_reg     <= q_ovf;
                last_reg    <= fin_lastrow_reg;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_row      = out_row_reg;
    assign dot_value    = dot_reg;
    assign saturated    = sat_reg;
    assign last         = last_reg;
    assign status.busy  = s1_tag_reg.valid || p_tag_reg.valid || fin_valid_reg;
    assign status.stall = stall;

endmodule

// ===== rtl/core/matrix_vector_multiply.sv =====
// ---------------------------------------------------------------------------
// matrix_vector_multiply
// Dense matrix-vector multiplier in signed Q7.8 with one shared MAC unit.
// ---------------------------------------------------------------------------
// Usage:
//   Input transfers carry either a weight (kind 0, row_index, col_index) or a
//   vector element (kind 1, col_index). After a weight or a non-final element
//   the block is ready again in the next cycle. The element whose index is
//   cols_in_use - 1 starts a multiply: the shared MAC reads one weight and one
//   element per cycle while the output is not stalled, row by row, and
//   in_ready stays low until the last dot product reaches the output register.
//   Results come in row order, with last on the final row. Each result is
//   floor(sum / 256) saturated to 16 bits.
//   The output register lets the next input be taken while the final result
//   waits; a stalled receiver freezes the MAC pipeline until it takes the
//   result, so nothing is lost.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
//   belong in idle periods. Reset sets both counts to their maximum; the
//   weight and vector stores are not cleared and must be written before use.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "matrix_vector_multiply_defines.svh"

module matrix_vector_multiply #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [mvm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [mvm_pkg::CNT_W-1:0]             cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  kind,
    input  logic [mvm_pkg::ROW_W-1:0]             row_index,
    input  logic [mvm_pkg::COL_W-1:0]             col_index,
    input  logic signed [mvm_pkg::DATA_W-1:0]     value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [mvm_pkg::ROW_W-1:0]             out_row,
    output logic signed [mvm_pkg::DATA_W-1:0]     dot_value,
    output logic                                  saturated,
    output logic                                  last
);

    localparam int W_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int WA_W    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
    localparam int VA_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    function automatic logic [mvm_pkg::CNT_W-1:0] clamp_count(
        input logic [mvm_pkg::CNT_W-1:0] v,
        input int                        maxv
    );
        logic [mvm_pkg::CNT_W-1:0] c;
        c = v;
        if (c == '0)
        begin
            c = mvm_pkg::CNT_W'(1);
        end
        if (int'(c) > maxv)
        begin
            c = mvm_pkg::CNT_W'(maxv);
        end
        return c;
    endfunction

    mvm_pkg::mvm_state_t         state_reg;
    mvm_pkg::mvm_state_t         state_next;
    logic [mvm_pkg::CNT_W-1:0]   rows_reg;
    logic [mvm_pkg::CNT_W-1:0]   cols_reg;
    logic [mvm_pkg::CNT_W-1:0]   r_reg;
    logic [mvm_pkg::CNT_W-1:0]   r_next;
    logic [mvm_pkg::CNT_W-1:0]   c_reg;
    logic [mvm_pkg::CNT_W-1:0]   c_next;
    logic                        in_xfer;
    logic                        w_we;
    logic                        v_we;
    logic                        vec_last_xfer;
    logic                        issue;
    mvm_pkg::mvm_tag_t           issue_tag;
    mvm_pkg::mvm_status_t        mac_stat;
    logic [WA_W-1:0]             w_waddr;
    logic [WA_W-1:0]             w_raddr;
    logic [mvm_pkg::DATA_W-1:0]  w_rdata;
    logic [mvm_pkg::DATA_W-1:0]  v_rdata;

    assign in_xfer = in_valid && in_ready;
    assign w_we    = in_xfer && (kind == mvm_pkg::KIND_WEIGHT)
                     && (int'(row_index) < MAX_ROWS) && (int'(col_index) < MAX_COLS);
    assign v_we    = in_xfer && (kind == mvm_pkg::KIND_VECTOR)
                     && (int'(col_index) < MAX_COLS);
    // The element that closes the vector is always inside the store.
    assign vec_last_xfer = v_we
                     && ({1'b0, col_index} == (cols_reg - mvm_pkg::CNT_W'(1)));

    assign w_waddr = WA_W'(32'(row_index) * MAX_COLS + 32'(col_index));
    assign w_raddr = WA_W'(32'(r_reg) * MAX_COLS + 32'(c_reg));

    assign issue             = (state_reg == mvm_pkg::ST_RUN) && !mac_stat.stall;
    assign issue_tag.valid   = issue;
    assign issue_tag.first   = (c_reg == '0);
    assign issue_tag.lastcol = (c_reg == (cols_reg - mvm_pkg::CNT_W'(1)));
    assign issue_tag.lastrow = (r_reg == (rows_reg - mvm_pkg::CNT_W'(1)));
    assign issue_tag.row     = r_reg[mvm_pkg::ROW_W-1:0];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= clamp_count(mvm_pkg::CNT_W'(16), MAX_ROWS);
            cols_reg <= clamp_count(mvm_pkg::CNT_W'(16), MAX_COLS);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mvm_pkg::CFG_ROWS_IN_USE: rows_reg <= clamp_count(cfg_data, MAX_ROWS);
                mvm_pkg::CFG_COLS_IN_USE: cols_reg <= clamp_count(cfg_data, MAX_COLS);
                default:                  ;
            endcase
        end
    end

    // Sequencer: next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mvm_pkg::ST_IDLE:
            begin
                if (vec_last_xfer)
                begin
                    state_next = mvm_pkg::ST_RUN;
                end
            end
            mvm_pkg::ST_RUN:
            begin
                if (issue && issue_tag.lastcol && issue_tag.lastrow)
                begin
                    state_next = mvm_pkg::ST_DRAIN;
                end
            end
            mvm_pkg::ST_DRAIN:
            begin
                if (!mac_stat.busy)
                begin
                    state_next = mvm_pkg::ST_IDLE;
                end
            end
            default: state_next = mvm_pkg::ST_IDLE;
        endcase
    end

    // Sequencer: outputs.
    always_comb
    begin
        in_ready = 1'b0;
        unique case (state_reg)
            mvm_pkg::ST_IDLE:  in_ready = 1'b1;
            mvm_pkg::ST_RUN:   in_ready = 1'b0;
            mvm_pkg::ST_DRAIN: in_ready = 1'b0;
            default:           in_ready = 1'b0;
        endcase
    end

    // Row and column counters walk the matrix one product per cycle while the MAC is not stalled.
    always_comb
    begin
        r_next = r_reg;
        c_next = c_reg;
        if (vec_last_xfer)
        begin
            r_next = '0;
            c_next = '0;
        end
        else if (issue)
        begin
            if (issue_tag.lastcol)
            begin
                c_next = '0;
                r_next = r_reg + mvm_pkg::CNT_W'(1);
            end
            else
            begin
                c_next = c_reg + mvm_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mvm_pkg::ST_IDLE;
            r_reg     <= '0;
            c_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
        end
    end

    mvm_ram #(
        .WIDTH (mvm_pkg::DATA_W),
        .DEPTH (W_DEPTH),
        .AW    (WA_W)
    ) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (value),
        .re    (issue),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    mvm_ram #(
        .WIDTH (mvm_pkg::DATA_W),
        .DEPTH (MAX_COLS),
        .AW    (VA_W)
    ) u_vector_ram (
        .clk   (clk),
        .we    (v_we),
        .waddr (VA_W'(col_index)),
        .wdata (value),
        .re    (issue),
        .raddr (VA_W'(c_reg)),
        .rdata (v_rdata)
    );

    mvm_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue_tag (issue_tag),
        .w_data    (w_rdata),
        .v_data    (v_rdata),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_row   (out_row),
        .dot_value (dot_value),
        .saturated (saturated),
        .last      (last),
        .status    (mac_stat)
    );

    `MVM_ASSERT_IMP(a_idle_pipe_empty, in_ready, !mac_stat.busy, "MAC busy while idle")
    `MVM_ASSERT_IMP(a_run_in_range, state_reg == mvm_pkg::ST_RUN,
        (r_reg < rows_reg) && (c_reg < cols_reg), "sequencer counter out of range")
    `MVM_ASSERT_NXT(a_vec_starts_run, vec_last_xfer, !in_ready,
        "final vector element did not start a multiply")

endmodule

// ===== bench/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the matrix-vector multiplier. A predictor keeps its
// own copy of the weight and vector stores and of both counts, and works out
// every row dot product when the last element of a vector is transferred.
// Results are compared field by field, in order, while both sides of the
// block idle and stall at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int STORE_ROWS    = 16;
    localparam int STORE_COLS    = 16;
    localparam int RANDOM_ITEMS  = 12;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 5000;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int PRINT_LIMIT   = 30;

    // Indexes past the end of the register list; writes to them are dropped.
    localparam logic [mvm_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [mvm_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam logic signed [mvm_pkg::DATA_W-1:0] VALUE_MAX = 16'sh7FFF;
    localparam logic signed [mvm_pkg::DATA_W-1:0] VALUE_MIN = 16'sh8000;

    typedef struct packed {
        logic [mvm_pkg::ROW_W-1:0]         row;
        logic signed [mvm_pkg::DATA_W-1:0] dot;
        logic                              sat;
        logic                              last;
    } dot_result_t;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              cfg_we    = 1'b0;
    logic [mvm_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [mvm_pkg::CNT_W-1:0]         cfg_data  = '0;
    logic                              in_valid  = 1'b0;
    logic                              in_ready;
    logic                              kind      = 1'b0;
    logic [mvm_pkg::ROW_W-1:0]         row_index = '0;
    logic [mvm_pkg::COL_W-1:0]         col_index = '0;
    logic signed [mvm_pkg::DATA_W-1:0] value     = '0;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic [mvm_pkg::ROW_W-1:0]         out_row;
    logic signed [mvm_pkg::DATA_W-1:0] dot_value;
    logic                              saturated;
    logic                              last;

    // Predictor state
    logic signed [mvm_pkg::DATA_W-1:0] weight_copy [STORE_ROWS][STORE_COLS];
    logic signed [mvm_pkg::DATA_W-1:0] vector_copy [STORE_COLS];
    int unsigned                       rows_cnt = STORE_ROWS;
    int unsigned                       cols_cnt = STORE_COLS;
    dot_result_t                       pending_dots [$];

    int          mismatches   = 0;
    int          items_sent   = 0;
    bit          tx_burst     = 1'b0;
    logic        rx_burst     = 1'b0;
    int unsigned hold_seq     = 0;
    int unsigned hold_seen    = 0;
    int unsigned rx_gap       = 0;
    int unsigned rx_hold      = 0;
    int unsigned quiet_cycles = 0;

    matrix_vector_multiply dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .row_index (row_index),
        .col_index (col_index),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_row   (out_row),
        .dot_value (dot_value),
        .saturated (saturated),
        .last      (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned clamp_count(input logic [mvm_pkg::CNT_W-1:0] v,
                                                input int unsigned maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    function automatic void predict_item(input logic k,
                                         input logic [mvm_pkg::ROW_W-1:0] r,
                                         input logic [mvm_pkg::COL_W-1:0] c,
                                         input logic signed [mvm_pkg::DATA_W-1:0] v);
        longint      acc;
        longint      q;
        dot_result_t res;
        // With the default store size every 4-bit index lies inside the store.
        if (k == mvm_pkg::KIND_WEIGHT)
        begin
            weight_copy[r][c] = v;
            return;
        end
        vector_copy[c] = v;
        if (c != cols_cnt - 1)
            return;
        for (int rr = 0; rr < rows_cnt; rr++)
        begin
            acc = 0;
            for (int cc = 0; cc < cols_cnt; cc++)
                acc += longint'(weight_copy[rr][cc]) * longint'(vector_copy[cc]);
            // Arithmetic shift of a signed value rounds toward minus infinity.
            q = acc >>> mvm_pkg::FRAC_W;
            res.sat = 1'b0;
            if (q > 32767)
            begin
                q = 32767;
                res.sat = 1'b1;
            end
            if (q < -32768)
            begin
                q = -32768;
                res.sat = 1'b1;
            end
            res.row  = rr[mvm_pkg::ROW_W-1:0];
            res.dot  = q[mvm_pkg::DATA_W-1:0];
            res.last = (rr == rows_cnt - 1);
            pending_dots = {pending_dots, res};
        end
    endfunction

    function automatic logic signed [mvm_pkg::DATA_W-1:0] rand_value();
        case ($urandom_range(0, 5))
            0:       return mvm_pkg::DATA_W'($urandom());
            1, 2, 3: return mvm_pkg::DATA_W'($urandom_range(0, 1023) - 512);
            4:       return VALUE_MAX;
            default: return VALUE_MIN;
        endcase
    endfunction

    function automatic logic [mvm_pkg::CNT_W-1:0] rand_count();
        case ($urandom_range(0, 3))
            0, 1:    return mvm_pkg::CNT_W'($urandom_range(1, 4));
            2:       return mvm_pkg::CNT_W'($urandom_range(5, 16));
            default: return $urandom_range(0, 1) ? mvm_pkg::CNT_W'($urandom_range(17, 31))
                                                 : mvm_pkg::CNT_W'(0);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Offers one item after a random gap (none in a burst) and holds it until the transfer.
    task automatic send_item(input logic k, input logic [mvm_pkg::ROW_W-1:0] r,
                             input logic [mvm_pkg::COL_W-1:0] c,
                             input logic signed [mvm_pkg::DATA_W-1:0] v);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        row_index <= r;
        col_index <= c;
        value     <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_item(k, r, c, v);
        items_sent++;
    endtask

    task automatic write_register(input logic [mvm_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [mvm_pkg::CNT_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == mvm_pkg::CFG_ROWS_IN_USE)
            rows_cnt = clamp_count(data, STORE_ROWS);
        else if (idx == mvm_pkg::CFG_COLS_IN_USE)
            cols_cnt = clamp_count(data, STORE_COLS);
    endtask

    // The block may still be finishing a pass after the final result.
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_dots.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_noise_item();
        send_item(1'($urandom_range(0, 1)), mvm_pkg::ROW_W'($urandom_range(0, 15)),
                  mvm_pkg::COL_W'($urandom_range(0, 15)), mvm_pkg::DATA_W'($urandom()));
    endtask

    // A few weight rewrites, then the elements in use in random order, some left
    // out, at times one past the columns in use, then the element that starts the multiply.
    task automatic send_vector_sequence();
        logic [mvm_pkg::COL_W-1:0] order [$];
        logic [mvm_pkg::COL_W-1:0] tmp;
        int unsigned               j;
        repeat ($urandom_range(0, 4))
            send_item(mvm_pkg::KIND_WEIGHT, mvm_pkg::ROW_W'($urandom_range(0, rows_cnt - 1)),
                      mvm_pkg::COL_W'($urandom_range(0, cols_cnt - 1)), rand_value());
        for (int c = 0; c < cols_cnt - 1; c++)
            if ($urandom_range(0, 7) != 0)
                order = {order, c[mvm_pkg::COL_W-1:0]};
        for (int i = order.size() - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        foreach (order[i])
            send_item(mvm_pkg::KIND_VECTOR, mvm_pkg::ROW_W'($urandom_range(0, 15)), order[i],
                      rand_value());
        if (cols_cnt < STORE_COLS && $urandom_range(0, 3) == 0)
            send_item(mvm_pkg::KIND_VECTOR, mvm_pkg::ROW_W'($urandom_range(0, 15)),
                      mvm_pkg::COL_W'($urandom_range(cols_cnt, STORE_COLS - 1)),
                      rand_value());
        send_item(mvm_pkg::KIND_VECTOR, mvm_pkg::ROW_W'($urandom_range(0, 15)),
                  mvm_pkg::COL_W'(cols_cnt - 1), rand_value());
    endtask

    // Fills both stores completely so that no later pass reads an unwritten
    // entry; the final element starts a full-size multiply at reset counts.
    task automatic test_load_stores();
        for (int r = 0; r < STORE_ROWS; r++)
            for (int c = 0; c < STORE_COLS; c++)
                send_item(mvm_pkg::KIND_WEIGHT, r[mvm_pkg::ROW_W-1:0], c[mvm_pkg::COL_W-1:0],
                          mvm_pkg::DATA_W'($urandom()));
        for (int c = 0; c < STORE_COLS; c++)
            send_item(mvm_pkg::KIND_VECTOR, mvm_pkg::ROW_W'($urandom_range(0, 15)),
                      c[mvm_pkg::COL_W-1:0], mvm_pkg::DATA_W'($urandom()));
        wait_results_drained();
    endtask

    task automatic test_saturation_and_rounding();
        write_register(mvm_pkg::CFG_ROWS_IN_USE, 5'd2);
        write_register(mvm_pkg::CFG_COLS_IN_USE, 5'd2);
        send_item(mvm_pkg::KIND_WEIGHT, 4'd0, 4'd0, VALUE_MAX);
        send_item(mvm_pkg::KIND_WEIGHT, 4'd0, 4'd1, VALUE_MAX);
        send_item(mvm_pkg::KIND_WEIGHT, 4'd1, 4'd0, VALUE_MIN);
        send_item(mvm_pkg::KIND_WEIGHT, 4'd1, 4'd1, VALUE_MAX);
        // Positive clip on row 0, small negative sum floored on row 1.
        send_item(mvm_pkg::KIND_VECTOR, 4'd0, 4'd0, VALUE_MAX);
        send_item(mvm_pkg::KIND_VECTOR, 4'd0, 4'd1, VALUE_MAX);
        // Negative clip on row 1.
        send_item(mvm_pkg::KIND_VECTOR, 4'd15, 4'd1, VALUE_MIN);
        // A sum of minus one must come out as minus one, not zero.
        send_item(mvm_pkg::KIND_WEIGHT, 4'd0, 4'd0, -16'sd1);
        send_item(mvm_pkg::KIND_WEIGHT, 4'd0, 4'd1, 16'sd0);
        send_item(mvm_pkg::KIND_VECTOR, 4'd0, 4'd0, 16'sd1);
        send_item(mvm_pkg::KIND_VECTOR, 4'd0, 4'd1, 16'sd0);
        // Plain Q7.8 products well inside range.
        send_item(mvm_pkg::KIND_WEIGHT, 4'd1, 4'd0, 16'sh0100);
        send_item(mvm_pkg::KIND_WEIGHT, 4'd1, 4'd1, 16'sh0100);
        send_item(mvm_pkg::KIND_VECTOR, 4'd0, 4'd0, 16'sh0080);
        send_item(mvm_pkg::KIND_VECTOR, 4'd0, 4'd1, -16'sh0180);
        wait_results_drained();
    endtask

    task automatic test_register_limits();
        // Zero counts are taken as one.
        write_register(mvm_pkg::CFG_ROWS_IN_USE, 5'd0);
        write_register(mvm_pkg::CFG_COLS_IN_USE, 5'd0);
        send_item(mvm_pkg::KIND_VECTOR, 4'd0, 4'd0, rand_value());
        wait_results_drained();
        // Writes past the register list change nothing.
        write_register(CFG_SPARE_LO, 5'd3);
        write_register(CFG_SPARE_HI, 5'd31);
        send_item(mvm_pkg::KIND_VECTOR, 4'd0, 4'd0, rand_value());
        wait_results_drained();
        // Elements out of order, one missing, one beyond the columns in use.
        write_register(mvm_pkg::CFG_ROWS_IN_USE, 5'd16);
        write_register(mvm_pkg::CFG_COLS_IN_USE, 5'd4);
        send_item(mvm_pkg::KIND_VECTOR, 4'd0, 4'd9, rand_value());
        send_item(mvm_pkg::KIND_VECTOR, 4'd0, 4'd2, rand_value());
        send_item(mvm_pkg::KIND_VECTOR, 4'd0, 4'd0, rand_value());
        send_item(mvm_pkg::KIND_VECTOR, 4'd0, 4'd3, rand_value());
        wait_results_drained();
        // Counts above the store size are taken as the store size.
        write_register(mvm_pkg::CFG_ROWS_IN_USE, 5'd31);
        write_register(mvm_pkg::CFG_COLS_IN_USE, 5'd17);
        send_item(mvm_pkg::KIND_VECTOR, 4'd0, 4'd15, rand_value());
        wait_results_drained();
    endtask

    // The receiver holds off while the sender keeps offering, so the block
    // fills up and stalls its input; then the sender waits for every result.
    task automatic test_backpressure();
        write_register(mvm_pkg::CFG_ROWS_IN_USE, 5'd16);
        write_register(mvm_pkg::CFG_COLS_IN_USE, 5'd2);
        tx_burst = 1'b1;
        hold_seq <= hold_seq + 1;
        repeat (8)
        begin
            send_item(mvm_pkg::KIND_VECTOR, mvm_pkg::ROW_W'($urandom_range(0, 15)), 4'd0,
                      rand_value());
            send_item(mvm_pkg::KIND_VECTOR, mvm_pkg::ROW_W'($urandom_range(0, 15)), 4'd1,
                      rand_value());
        end
        tx_burst = 1'b0;
        wait_results_drained();
    endtask

    task automatic test_random_traffic();
        int target;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            wait_results_drained();
            if ($urandom_range(0, 2) == 0)
                write_register(mvm_pkg::CFG_ROWS_IN_USE, rand_count());
            if ($urandom_range(0, 2) == 0)
                write_register(mvm_pkg::CFG_COLS_IN_USE, rand_count());
            tx_burst = ($urandom_range(0, 4) == 0);
            rx_burst <= ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(1, 2))
            begin
                if ($urandom_range(0, 4) == 0)
                    send_noise_item();
                else
                    send_vector_sequence();
            end
        end
        tx_burst = 1'b0;
        rx_burst <= 1'b0;
    endtask

    // Receiver: a random gap before each transfer outside bursts, plus one long hold-off.
    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen = hold_seq;
            rx_hold   = LONG_HOLD;
        end
        if (out_valid && out_ready)
            rx_gap = rx_burst ? 0 : $urandom_range(0, 15);
        else if (rx_gap != 0)
            rx_gap--;
        if (rx_hold != 0)
            rx_hold--;
        out_ready <= (rx_gap == 0) && (rx_hold == 0);
    end

    always @(posedge clk)
    begin
        dot_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_dots.size() == 0)
                report_mismatch("result with nothing pending, row", out_row, 0);
            else
            begin
                want = pending_dots.pop_front();
                if (out_row !== want.row)
                    report_mismatch("out_row", out_row, want.row);
                if (dot_value !== want.dot)
                    report_mismatch("dot_value", dot_value, want.dot);
                if (saturated !== want.sat)
                    report_mismatch("saturated", saturated, want.sat);
                if (last !== want.last)
                    report_mismatch("last", last, want.last);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("matrix_vector_multiply regression: fail");
            $finish;
        end
    end

    initial
    begin
        int waited;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_load_stores();
        test_saturation_and_rounding();
        test_register_limits();
        test_backpressure();
        test_random_traffic();
        in_valid <= 1'b0;
        waited = 0;
        while (pending_dots.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_dots.size() != 0)
            report_mismatch("results never delivered", pending_dots.size(), 0);
        if (mismatches == 0)
            $display("matrix_vector_multiply regression: pass");
        else
            $display("matrix_vector_multiply regression: fail");
        $finish;
    end

endmodule
